>>> hw/rtl/wsq_pkg.sv
// ----------------------------------------------------------------------------
// wsq_pkg
// Shared types and constants of the two-class weighted service queue.
// ----------------------------------------------------------------------------
package wsq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int ID_WIDTH        = 16;
   localparam int AGE_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BURST_LIMIT   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AGE_THRESHOLD = CSR_INDEX_WIDTH'(1);

   localparam logic [CSR_DATA_WIDTH-1:0] BURST_LIMIT_RESET   = 8'd3;
   localparam logic [CSR_DATA_WIDTH-1:0] AGE_THRESHOLD_RESET = 8'd60;

   typedef enum logic {
      MODE_ADD   = 1'b0,
      MODE_SERVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_SERVED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]  id;
      logic [AGE_WIDTH-1:0] age;
   } entry_type;

   // per-cell control: load the pushed entry, or shift from the upper neighbor
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

>>> hw/rtl/wsq_ifs.sv
// ----------------------------------------------------------------------------
// wsq interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsq_req_if;
   import wsq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [ID_WIDTH-1:0]  entry_id;
   logic [AGE_WIDTH-1:0] entry_age;

   modport source (output valid, mode, entry_id, entry_age, input ready);
   modport sink   (input valid, mode, entry_id, entry_age, output ready);
endinterface

interface wsq_rsp_if;
   import wsq_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ID_WIDTH-1:0]  served_id;
   logic [AGE_WIDTH-1:0] served_age;
   logic                 from_priority;

   modport source (output valid, status, served_id, served_age, from_priority,
                   input ready);
   modport sink   (input valid, status, served_id, served_age, from_priority,
                   output ready);
endinterface

interface wsq_csr_if;
   import wsq_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wsq_cell.sv
// ----------------------------------------------------------------------------
// wsq_cell
// One queue slot: loads a pushed entry or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module wsq_cell (
   input  logic                  clock,
   input  wsq_pkg::cell_ctl_type ctl,
   input  wsq_pkg::entry_type    load_data,
   input  wsq_pkg::entry_type    next_data,
   output wsq_pkg::entry_type    data
);
   import wsq_pkg::*;

   entry_type data_ff;
   entry_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> hw/rtl/wsq_chain.sv
// ----------------------------------------------------------------------------
// wsq_chain
// FIFO built as a row of cells; the head sits in cell 0 and a pop shifts
// every cell down by one. A push lands in the cell at the fill count.
// ----------------------------------------------------------------------------
module wsq_chain #(
   parameter int QUEUE_DEPTH = wsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic                               pop,
   input  wsq_pkg::entry_type                 push_data,
   output wsq_pkg::entry_type                 head_data,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
   output logic                               empty,
   output logic                               full
);
   import wsq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   entry_type     cell_data [QUEUE_DEPTH];
   entry_type     next_data [QUEUE_DEPTH];
   cell_ctl_type  cell_ctl  [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign next_data[i] = cell_data[i];
      end else begin : g_mid
         assign next_data[i] = cell_data[i+1];
      end

      assign cell_ctl[i].load  = push && (count_ff == CW'(i));
      assign cell_ctl[i].shift = pop;

      wsq_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .load_data (push_data),
         .next_data (next_data[i]),
         .data      (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CW'(1);
      end else if (pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_data = cell_data[0];
   assign count     = count_ff;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));

endmodule

>>> hw/rtl/two_class_weighted_service_queue_top.sv
// The response is registered and shows in the cycle after the request.
// Throughput: one request per cycle unless a held response is not yet taken;
// each add or serve moves at most one cell chain; only serves change credit.
// Reset: fill counts clear, credit and burst limit go to 3, age threshold
// to 60; queue cells are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// two_class_weighted_service_queue_top
// Priority and normal queues served by a credit-based weighted round robin.
// ----------------------------------------------------------------------------
module two_class_weighted_service_queue_top #(
   parameter int QUEUE_DEPTH = wsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   wsq_req_if.sink   req_ch,
   wsq_rsp_if.source rsp_ch,
   wsq_csr_if.sink   csr_ch
);
   import wsq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // registers
   logic [CSR_DATA_WIDTH-1:0] burst_limit_ff;
   logic [CSR_DATA_WIDTH-1:0] age_threshold_ff;
   logic [CSR_DATA_WIDTH-1:0] credit_ff;
   logic [CSR_DATA_WIDTH-1:0] credit_in;

   logic                      rsp_valid_ff;
   status_type                status_ff;
   status_type                status_in;
   entry_type                 served_ff;
   entry_type                 served_in;
   logic                      prio_ff;
   logic                      prio_in;

   logic      accept;
   logic      is_add;
   logic      add_prio;
   logic      p_push, p_pop, n_push, n_pop;
   entry_type p_head, n_head, new_entry;
   logic      p_empty, p_full, n_empty, n_full;
   logic [CW-1:0] p_count, n_count;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_add       = (mode_type'(req_ch.mode) == MODE_ADD);
   assign add_prio     = (req_ch.entry_age > age_threshold_ff);
   assign new_entry    = '{id: req_ch.entry_id, age: req_ch.entry_age};

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_limit_ff   <= BURST_LIMIT_RESET;
         age_threshold_ff <= AGE_THRESHOLD_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BURST_LIMIT:   burst_limit_ff   <= csr_ch.data;
            CSR_AGE_THRESHOLD: age_threshold_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // classify adds, arbitrate serves by credit
   always_comb begin
      p_push    = 1'b0;
      n_push    = 1'b0;
      p_pop     = 1'b0;
      n_pop     = 1'b0;
      credit_in = credit_ff;
      status_in = ST_EMPTY;
      served_in = '0;
      prio_in   = 1'b0;
      if (accept) begin
         if (is_add) begin
            prio_in = add_prio;
            if (add_prio) begin
               p_push    = !p_full;
               status_in = p_full ? ST_FULL : ST_ADDED;
            end else begin
               n_push    = !n_full;
               status_in = n_full ? ST_FULL : ST_ADDED;
            end
         end else if (credit_ff != '0) begin
            priority if (!p_empty) begin
               p_pop     = 1'b1;
               prio_in   = 1'b1;
               credit_in = credit_ff - CSR_DATA_WIDTH'(1);
               served_in = p_head;
               status_in = ST_SERVED;
            end else if (!n_empty) begin
               n_pop     = 1'b1;
               served_in = n_head;
               status_in = ST_SERVED;
            end
         end else begin
            priority if (!n_empty) begin
               n_pop     = 1'b1;
               credit_in = burst_limit_ff;
               served_in = n_head;
               status_in = ST_SERVED;
            end else if (!p_empty) begin
               p_pop     = 1'b1;
               prio_in   = 1'b1;
               served_in = p_head;
               status_in = ST_SERVED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff    <= BURST_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the response payload until the next transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         served_ff <= served_in;
         prio_ff   <= prio_in;
      end
   end

   wsq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_prio_chain (
      .clock     (clock),
      .reset     (reset),
      .push      (p_push),
      .pop       (p_pop),
      .push_data (new_entry),
      .head_data (p_head),
      .count     (p_count),
      .empty     (p_empty),
      .full      (p_full)
   );

   wsq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_norm_chain (
      .clock     (clock),
      .reset     (reset),
      .push      (n_push),
      .pop       (n_pop),
      .push_data (new_entry),
      .head_data (n_head),
      .count     (n_count),
      .empty     (n_empty),
      .full      (n_full)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.served_id     = served_ff.id;
   assign rsp_ch.served_age    = served_ff.age;
   assign rsp_ch.from_priority = prio_ff;

   // assertions
   a_credit_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(credit_ff))
      else $error("credit changed without a transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (p_count <= CW'(QUEUE_DEPTH)) && (n_count <= CW'(QUEUE_DEPTH)))
      else $error("queue fill count beyond depth");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_EMPTY) |->
         (served_ff == '0) && !prio_ff)
      else $error("empty response carries data");

   a_add_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((status_ff == ST_ADDED) || (status_ff == ST_FULL)) |->
         (served_ff == '0))
      else $error("add response carries served data");

endmodule
